FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check with no reset gating.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/ism_pkg.sv
// ---------------------------------------------------------------------------
// ism_pkg
// Types and codes shared by the interval set core.
// ---------------------------------------------------------------------------
package ism_pkg;

   // width of the position space; stored ends carry one more bit
   localparam int POS_BITS = 32;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] range_start;
      logic [31:0] range_length;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] entry_start;
      logic [32:0] entry_end;
      logic [6:0]  interval_count;
   } rsp_type;

endpackage

FILE: rtl/core/interval_set_merge_split_core.sv
// ---------------------------------------------------------------------------
// interval_set_merge_split_core
// Sorted set of disjoint half-open intervals with merging insert and
// trimming / splitting remove, held in a memory with a registered read.
// ---------------------------------------------------------------------------
//  channel | direction | payload  | handshake
//  req     | in        | req_type | req_valid / req_stall
//  rsp     | out       | rsp_type | rsp_valid / rsp_stall
//
//  One item at a time. An insert or remove runs a scan pass (skipped on an
//  empty set) and a rewrite pass over the stored entries, entry by entry
//  through the single memory read port. A read passes through the read and
//  read-wait states before the result beat.
//  Reset clears state, count and valid flags only; no clearing pass. The
//  result is held in an output register; while it is stalled the next beat is not taken.
`include "assert_macros.svh"

module interval_set_merge_split_core #(
   parameter int CAPACITY = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ism_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ism_pkg::rsp_type rsp_data
);
   import ism_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = POS_BITS + 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SCANW = 7'b0000100,
      S_EDIT  = 7'b0001000,
      S_EDITW = 7'b0010000,
      S_READ  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // memory: start in low bits, end above
   logic [POS_BITS+EW-1:0] mem [CAPACITY];
   logic [POS_BITS+EW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [POS_BITS+EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;        // read pointer
   logic [CW-1:0] w_ff, w_in;        // write pointer
   logic [1:0]  act_ff, act_in;
   logic [EW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic          split_ff, split_in; // remove: split found
   logic          placed_ff, placed_in; // insert: merged entry placed
   logic [CW-1:0] first_ff, first_in, past_ff, past_in;
   logic [EW-1:0] mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [CW-1:0] sk_ff, sk_in;
   logic [EW-1:0] send_ff, send_in;
   logic          pend_ff, pend_in;   // pending carried entry
   logic [POS_BITS+EW-1:0] carry_ff, carry_in;
   logic          rv_ff, rv_in;
   rsp_type       rsp_ff, rsp_in;

   logic [EW-1:0] cs, ce, stop;
   assign cs = {1'b0, rd_ff[POS_BITS-1:0]};
   assign ce = rd_ff[POS_BITS+EW-1:POS_BITS];

   always_comb begin
      logic [32:0] sum;
      sum  = {1'b0, req_data.range_start} + {1'b0, req_data.range_length};
      stop = (sum > 33'((64'd1 << POS_BITS))) ? EW'(64'd1 << POS_BITS) : EW'(sum);
   end

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [EW-1:0] a_s, a_e;
      state_in = state_ff; count_in = count_ff; k_in = k_ff; w_in = w_ff;
      act_in = act_ff; lo_in = lo_ff; hi_in = hi_ff; split_in = split_ff;
      placed_in = placed_ff; first_in = first_ff; past_in = past_ff;
      mlo_in = mlo_ff; mhi_in = mhi_ff; sk_in = sk_ff; send_in = send_ff;
      pend_in = pend_ff; carry_in = carry_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      rd_addr = k_ff[AW-1:0]; wr_en = 1'b0; wr_addr = w_ff[AW-1:0];
      wr_data = carry_ff; a_s = '0; a_e = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               act_in = req_data.action;
               lo_in = {1'b0, req_data.range_start[POS_BITS-1:0]};
               hi_in = stop;
               mlo_in = lo_in; mhi_in = stop;
               k_in = '0; w_in = '0; split_in = 1'b0; placed_in = 1'b0;
               first_in = count_ff; past_in = count_ff;
               rsp_in = '0;
               rsp_in.status = ST_DONE;
               if ((req_data.action == ACT_INSERT || req_data.action == ACT_REMOVE)
                   && req_data.range_length != '0) begin
                  if (count_ff == '0) state_in = S_EDIT;
                  else state_in = S_SCAN;
               end else if (req_data.action == ACT_READ) begin
                  if (32'(req_data.entry_index) >= 32'(count_ff)) begin
                     rsp_in.status = ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     k_in = CW'(req_data.entry_index);
                     state_in = S_READ;
                  end
               end else state_in = S_DONE;
            end
         end
         S_READ: state_in = S_SCANW;
         S_SCAN: state_in = S_SCANW; // rd_ff of k valid next cycle
         S_SCANW: begin
            if (act_ff == ACT_READ) begin
               rsp_in.entry_start = 32'(cs);
               rsp_in.entry_end = 33'(ce);
               state_in = S_DONE;
            end else begin
               if (act_ff == ACT_INSERT) begin
                  if (ce >= lo_ff && cs <= hi_ff) begin
                     if (first_ff == count_ff) first_in = k_ff;
                     past_in = k_ff + 1'b1;
                     if (cs < mlo_ff) mlo_in = cs;
                     if (ce > mhi_ff) mhi_in = ce;
                  end else if (ce < lo_ff) begin
                     first_in = count_ff; past_in = count_ff;
                  end else if (first_ff == count_ff) begin
                     first_in = k_ff; past_in = k_ff;
                  end
               end else if (!split_ff && cs < lo_ff && hi_ff < ce) begin
                  split_in = 1'b1; sk_in = k_ff; send_in = ce;
               end
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == count_ff) begin
                  k_in = '0;
                  state_in = S_EDIT;
                  if (act_ff == ACT_INSERT && first_ff == count_ff
                      && !(ce >= lo_ff && cs <= hi_ff) && !(ce < lo_ff)) begin
                     first_in = k_ff; past_in = k_ff;
                  end
               end else state_in = S_SCAN;
            end
         end
         S_EDIT: begin
            // decide drop, then stream rewrite; k_ff reads, w_ff writes
            if (act_ff == ACT_INSERT && k_ff == '0 && !placed_ff && w_ff == '0
                && (count_ff - (past_ff - first_ff)) >= CW'(CAPACITY)) begin
               rsp_in.status = ST_FULL; state_in = S_DONE;
            end else if (act_ff == ACT_REMOVE && split_ff && k_ff == '0
                         && w_ff == '0 && count_ff >= CW'(CAPACITY)) begin
               rsp_in.status = ST_FULL; state_in = S_DONE;
            end else if (act_ff == ACT_INSERT && !placed_ff && k_ff == first_ff) begin
               // merged entry rides the carry so a shift up never clobbers
               // an entry before it is read
               carry_in = {mhi_ff, mlo_ff[POS_BITS-1:0]};
               pend_in = 1'b1; placed_in = 1'b1; k_in = past_ff;
            end else if (pend_ff && k_ff >= count_ff) begin
               wr_en = 1'b1; wr_data = carry_ff; pend_in = 1'b0;
               count_in = w_ff + 1'b1; state_in = S_DONE;
            end else if (k_ff >= count_ff) begin
               count_in = w_ff; state_in = S_DONE;
            end else state_in = S_EDITW;
         end
         S_EDITW: begin
            a_s = cs; a_e = ce;
            k_in = k_ff + 1'b1;
            state_in = S_EDIT;
            if (act_ff == ACT_INSERT) begin
               wr_en = 1'b1; w_in = w_ff + 1'b1;
               if (pend_ff) carry_in = rd_ff;
               else wr_data = rd_ff;
            end else if (split_ff) begin
               // in-place split: shift up by one from sk
               if (k_ff == sk_ff) begin
                  wr_en = 1'b1; wr_addr = w_ff[AW-1:0];
                  wr_data = {lo_ff, cs[POS_BITS-1:0]};
                  carry_in = {send_ff, hi_ff[POS_BITS-1:0]};
                  pend_in = 1'b1; w_in = w_ff + 1'b1;
               end else if (k_ff > sk_ff) begin
                  wr_en = 1'b1; wr_data = carry_ff;
                  carry_in = rd_ff; w_in = w_ff + 1'b1;
               end else begin
                  wr_en = 1'b1; wr_data = rd_ff; w_in = w_ff + 1'b1;
               end
            end else begin
               if (ce > lo_ff && cs < hi_ff) begin
                  if (lo_ff <= cs) a_s = hi_ff; else a_e = lo_ff;
               end
               if (!(ce > lo_ff && cs < hi_ff && lo_ff <= cs && hi_ff >= ce)) begin
                  wr_en = 1'b1; wr_data = {a_e, a_s[POS_BITS-1:0]};
                  w_in = w_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rsp_in.interval_count = 7'(count_ff);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         pend_ff <= pend_in;
      end
      k_ff <= k_in; w_ff <= w_in; act_ff <= act_in; lo_ff <= lo_in; hi_ff <= hi_in;
      split_ff <= split_in; placed_ff <= placed_in; first_ff <= first_in;
      past_ff <= past_in; mlo_ff <= mlo_in; mhi_ff <= mhi_in; sk_ff <= sk_in;
      send_ff <= send_in; carry_ff <= carry_in; rsp_ff <= rsp_in;
   end

   `ASSERT_CLK(a_count_cap, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `ASSERT_CLK(a_one_item, clock, reset, (req_valid && !req_stall) |=> state_ff != S_IDLE,
      "item accepted but core idle")
   `ASSERT_CLK(a_rsp_range, clock, reset, $rose(rv_ff) |-> rsp_ff.status <= ST_RANGE,
      "bad status code")
endmodule

FILE: test/interval_set_merge_split_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_set_merge_split_core_tb
// Drives insert, remove and read beats into the interval set core, keeps a
// shadow copy of the sorted interval set, and checks every response beat
// field by field against the predicted one, in order.
// ---------------------------------------------------------------------------

class interval_scoreboard;
   localparam int CAP = 64;
   localparam logic [32:0] POS_END = 33'h1_0000_0000;

   logic [32:0] starts[CAP];
   logic [32:0] ends[CAP];
   int unsigned count;
   ism_pkg::rsp_type pending[$];
   int errors;

   function new();
      count = 0;
      errors = 0;
   endfunction

   function logic [1:0] merge_in(logic [32:0] lo, logic [32:0] hi);
      int unsigned first, past, merged, newcnt, k;
      first = 0;
      while (first < count && ends[first] < lo) first++;
      past = first;
      while (past < count && starts[past] <= hi) begin
         if (starts[past] < lo) lo = starts[past];
         if (ends[past] > hi) hi = ends[past];
         past++;
      end
      merged = past - first;
      newcnt = count - merged + 1;
      if (newcnt > CAP) return ism_pkg::ST_FULL;
      if (first + 1 <= past) begin
         for (k = 0; k < count - past; k++) begin
            starts[first + 1 + k] = starts[past + k];
            ends[first + 1 + k] = ends[past + k];
         end
      end else begin
         for (k = count - past; k > 0; k--) begin
            starts[first + k] = starts[past + k - 1];
            ends[first + k] = ends[past + k - 1];
         end
      end
      starts[first] = lo;
      ends[first] = hi;
      count = newcnt;
      return ism_pkg::ST_DONE;
   endfunction

   function logic [1:0] cut_out(logic [32:0] lo, logic [32:0] hi);
      int unsigned k, kept;
      logic [32:0] cs, ce, old_end;
      for (k = 0; k < count; k++) begin
         if (starts[k] < lo && hi < ends[k]) begin
            if (count >= CAP) return ism_pkg::ST_FULL;
            old_end = ends[k];
            for (int j = count; j > k + 1; j--) begin
               starts[j] = starts[j - 1];
               ends[j] = ends[j - 1];
            end
            ends[k] = lo;
            starts[k + 1] = hi;
            ends[k + 1] = old_end;
            count++;
            return ism_pkg::ST_DONE;
         end
      end
      kept = 0;
      for (k = 0; k < count; k++) begin
         cs = starts[k];
         ce = ends[k];
         if (ce > lo && cs < hi) begin
            if (lo <= cs && hi >= ce) continue;
            if (lo <= cs) cs = hi;
            else ce = lo;
         end
         starts[kept] = cs;
         ends[kept] = ce;
         kept++;
      end
      count = kept;
      return ism_pkg::ST_DONE;
   endfunction

   function void note_request(ism_pkg::req_type r);
      ism_pkg::rsp_type e;
      logic [32:0] lo, hi;
      e = '0;
      lo = {1'b0, r.range_start};
      hi = lo + {1'b0, r.range_length};
      if (hi > POS_END) hi = POS_END;
      if (r.action == ism_pkg::ACT_INSERT || r.action == ism_pkg::ACT_REMOVE) begin
         if (r.range_length != 0)
            e.status = (r.action == ism_pkg::ACT_INSERT) ? merge_in(lo, hi) : cut_out(lo, hi);
      end else if (r.action == ism_pkg::ACT_READ) begin
         if (r.entry_index < count) begin
            e.entry_start = starts[r.entry_index][31:0];
            e.entry_end = ends[r.entry_index];
         end else begin
            e.status = ism_pkg::ST_RANGE;
         end
      end
      e.interval_count = count[6:0];
      pending.push_back(e);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task check_response(ism_pkg::rsp_type g);
      ism_pkg::rsp_type e;
      if (pending.size() == 0) begin
         report("unexpected beat", 64'd0, 64'd0);
         return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", 64'(g.status), 64'(e.status));
      if (g.entry_start !== e.entry_start)
         report("entry_start", 64'(g.entry_start), 64'(e.entry_start));
      if (g.entry_end !== e.entry_end)
         report("entry_end", 64'(g.entry_end), 64'(e.entry_end));
      if (g.interval_count !== e.interval_count)
         report("interval_count", 64'(g.interval_count), 64'(e.interval_count));
   endtask
endclass

module interval_set_merge_split_core_tb;
   import ism_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   interval_scoreboard sb = new();
   longint cycles = 0;
   bit quiet_stretch = 0;

   interval_set_merge_split_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         rsp_stall <= (!quiet_stretch && $urandom_range(99) < 25);
      end
   end

   // valid stays up after an accepted beat until the next beat or an idle
   task automatic send_beat(req_type r);
      while (!quiet_stretch && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_op(logic [1:0] act, logic [31:0] st, logic [31:0] len, logic [5:0] idx);
      req_type r;
      r.action = act;
      r.range_start = st;
      r.range_length = len;
      r.entry_index = idx;
      send_beat(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // positions drawn from 0 to span; a narrow span makes inserts and removes interact
   function automatic logic [31:0] near_pos(int unsigned span);
      return $urandom_range(span);
   endfunction

   task automatic random_op(int unsigned span);
      int unsigned sel;
      logic [31:0] len;
      sel = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, span / 16 + 1);
      if ($urandom_range(19) == 0) len = 0;
      if (sel < 45)
         send_op(ACT_INSERT, near_pos(span), len, 6'($urandom));
      else if (sel < 75)
         send_op(ACT_REMOVE, near_pos(span), len, 6'($urandom));
      else if (sel < 97)
         send_op(ACT_READ, $urandom, $urandom,
                 6'($urandom_range(sb.count + 2 > 63 ? 63 : sb.count + 2)));
      else
         send_op(ACT_UNUSED, $urandom, $urandom, 6'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, zero length, extremes, merge, split, trim
      send_op(ACT_READ, 0, 0, 0);
      send_op(ACT_INSERT, 32'd100, 32'd0, 0);
      send_op(ACT_REMOVE, 32'd100, 32'd0, 0);
      send_op(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
      send_op(ACT_INSERT, 32'd0, 32'd1, 0);
      send_op(ACT_INSERT, 32'd10, 32'd10, 0);
      send_op(ACT_INSERT, 32'd20, 32'd5, 0);
      send_op(ACT_INSERT, 32'd1, 32'd9, 0);
      send_op(ACT_READ, 0, 0, 0);
      send_op(ACT_READ, 0, 0, 1);
      send_op(ACT_REMOVE, 32'd5, 32'd3, 0);
      send_op(ACT_REMOVE, 32'd0, 32'd2, 0);
      send_op(ACT_REMOVE, 32'd20, 32'd100, 0);
      send_op(ACT_READ, 0, 0, 6'd63);
      send_op(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
      send_op(ACT_REMOVE, 32'd0, 32'hFFFF_FFFF, 0);
      send_op(ACT_REMOVE, 32'hFFFF_FFFF, 32'd1, 0);

      // fill to capacity, then hit full on insert and trim entries while full
      for (int i = 0; i < 64; i++) send_op(ACT_INSERT, i * 4, 2, 0);
      send_op(ACT_INSERT, 32'd1000, 32'd1, 0);
      send_op(ACT_REMOVE, 32'd0, 32'd1, 0);
      send_op(ACT_INSERT, 32'd2000, 32'd1, 0);
      send_op(ACT_INSERT, 32'd2, 32'd1, 0);
      send_op(ACT_READ, 0, 0, 6'd63);
      send_op(ACT_REMOVE, 32'd5, 32'd2, 0);
      wait_drained();

      quiet_stretch = 1;
      for (int i = 0; i < 200; i++) random_op(4000);
      quiet_stretch = 0;
      for (int i = 0; i < RANDOM_ITEMS - 200; i++) begin
         if (i == 500) wait_drained();
         if (i % 400 == 300) send_op(ACT_REMOVE, 0, 32'hFFFF_FFFF, 0);
         random_op((i % 3 == 0) ? 600 : ((i % 7 == 0) ? 32'hFFFF_FFFF : 20000));
      end
      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ism_pkg.sv
rtl/core/interval_set_merge_split_core.sv
test/interval_set_merge_split_core_tb.sv
